@@ hw/rtl/srtl_pkg.sv @@
// Shared types and constants for the sorted range table lookup block.
package srtl_pkg;

   localparam int CAPACITY = 256;
   localparam int IDX_W    = $clog2(CAPACITY);
   localparam int CNT_W    = $clog2(CAPACITY + 1);
   localparam int ADDR_W   = 64;
   localparam int SEQ_W    = 8;

   typedef logic [IDX_W-1:0]  index_type;
   typedef logic [CNT_W-1:0]  count_type;
   typedef logic [ADDR_W-1:0] addr_type;
   typedef logic [SEQ_W-1:0]  seq_type;

   localparam count_type CAP_COUNT = count_type'(CAPACITY);

   typedef enum logic {
      FUNC_INSERT = 1'b0,
      FUNC_LOOKUP = 1'b1
   } func_type;

   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_NOT_FOUND = 2'd1,
      STATUS_FULL      = 2'd2,
      STATUS_RSVD      = 2'd3
   } status_type;

   typedef struct packed {
      func_type func;
      addr_type range_start;
      addr_type range_end;
      addr_type probe_address;
   } req_type;

   typedef struct packed {
      status_type status;
      addr_type   hit_start;
      addr_type   hit_end;
      seq_type    hit_sequence;
   } rsp_type;

   typedef struct packed {
      addr_type start_addr;
      addr_type end_addr;
      seq_type  seq;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

endpackage

@@ hw/rtl/srtl_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
module srtl_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hw/rtl/sorted_range_table_lookup.sv @@
// Top level: sorted range table with insertion shift and binary-search lookup.
//
//   Channel  Direction  Handshake             Payload
//   req      in         req_valid/req_stall   srtl_pkg::req_type
//   rsp      out        rsp_valid/rsp_stall   srtl_pkg::rsp_type
//
// An insert walks down from the top entry, moving each larger entry up one
// slot; the entry table is one RAM with a registered read, and each moved
// entry costs one read and one compare-and-write.
// A lookup is a binary search in which each probe is one read and one compare.
// A full-table insert is answered from idle without touching the table.
// Reset clears the entry count and the control state; the table needs no clearing
// pass. req_stall is high while a transaction is in progress or a result is
// pending; a finished result waits in its own register while rsp_stall is high.
module sorted_range_table_lookup (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  srtl_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output srtl_pkg::rsp_type rsp_data
);

   typedef enum logic [5:0] {
      ST_IDLE    = 6'b000001,
      ST_INS_RD  = 6'b000010,
      ST_INS_CMP = 6'b000100,
      ST_INS_PUT = 6'b001000,
      ST_LK_RD   = 6'b010000,
      ST_LK_CMP  = 6'b100000
   } state_type;

   state_type state_ff, state_in;
   logic      pend_ff, pend_in;

   srtl_pkg::req_type   req_ff, req_in;
   srtl_pkg::rsp_type   res_ff, res_in;
   srtl_pkg::count_type count_ff, count_in;
   srtl_pkg::count_type idx_ff, idx_in;
   srtl_pkg::count_type lo_ff, lo_in;
   srtl_pkg::count_type hi1_ff, hi1_in;
   srtl_pkg::count_type mid_ff, mid_in;
   srtl_pkg::count_type mid_calc;

   logic                rsp_valid_ff, rsp_valid_in;
   srtl_pkg::rsp_type   rsp_data_ff, rsp_data_in;

   logic                     ram_wr_en;
   srtl_pkg::index_type      ram_wr_addr;
   srtl_pkg::entry_type      ram_wr_entry;
   srtl_pkg::index_type      ram_rd_addr;
   logic [srtl_pkg::ENTRY_W-1:0] ram_rd_data;
   srtl_pkg::entry_type      rd_entry;
   srtl_pkg::entry_type      new_entry;

   logic req_take;
   logic out_free;

   assign rd_entry  = ram_rd_data;
   assign req_stall = (state_ff != ST_IDLE) || pend_ff;
   assign req_take  = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   assign new_entry.start_addr = req_ff.range_start;
   assign new_entry.end_addr   = req_ff.range_end;
   assign new_entry.seq        = srtl_pkg::seq_type'(count_ff);

   // Midpoint of the open search window [lo, hi1); only used when lo < hi1.
   assign mid_calc = lo_ff + ((hi1_ff - lo_ff - srtl_pkg::count_type'(1)) >> 1);

   srtl_ram #(
      .WIDTH (srtl_pkg::ENTRY_W),
      .DEPTH (srtl_pkg::CAPACITY)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_entry),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   always_comb begin
      state_in     = state_ff;
      pend_in      = pend_ff;
      req_in       = req_ff;
      res_in       = res_ff;
      count_in     = count_ff;
      idx_in       = idx_ff;
      lo_in        = lo_ff;
      hi1_in       = hi1_ff;
      mid_in       = mid_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      ram_wr_en    = 1'b0;
      ram_wr_addr  = srtl_pkg::index_type'(idx_ff);
      ram_wr_entry = new_entry;
      ram_rd_addr  = srtl_pkg::index_type'(idx_ff - srtl_pkg::count_type'(1));

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      if (pend_ff && out_free) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = res_ff;
         pend_in      = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               req_in = req_data;
               idx_in = count_ff;
               lo_in  = '0;
               hi1_in = count_ff;
               if (req_data.func == srtl_pkg::FUNC_LOOKUP) begin
                  state_in = ST_LK_RD;
               end else if (count_ff == srtl_pkg::CAP_COUNT) begin
                  res_in   = '{srtl_pkg::STATUS_FULL, '0, '0, '0};
                  pend_in  = 1'b1;
               end else if (count_ff == '0) begin
                  state_in = ST_INS_PUT;
               end else begin
                  state_in = ST_INS_RD;
               end
            end
         end
         ST_INS_RD: begin
            state_in = ST_INS_CMP;
         end
         ST_INS_CMP: begin
            ram_wr_en = 1'b1;
            if (rd_entry.start_addr > req_ff.range_start) begin
               // Move the larger entry up one slot and keep walking down.
               ram_wr_entry = rd_entry;
               idx_in       = idx_ff - srtl_pkg::count_type'(1);
               state_in     = (idx_ff == srtl_pkg::count_type'(1)) ? ST_INS_PUT : ST_INS_RD;
            end else begin
               res_in   = '{srtl_pkg::STATUS_OK, req_ff.range_start, req_ff.range_end,
                            new_entry.seq};
               count_in = count_ff + srtl_pkg::count_type'(1);
               pend_in  = 1'b1;
               state_in = ST_IDLE;
            end
         end
         ST_INS_PUT: begin
            ram_wr_en = 1'b1;
            res_in    = '{srtl_pkg::STATUS_OK, req_ff.range_start, req_ff.range_end,
                          new_entry.seq};
            count_in  = count_ff + srtl_pkg::count_type'(1);
            pend_in   = 1'b1;
            state_in  = ST_IDLE;
         end
         ST_LK_RD: begin
            ram_rd_addr = srtl_pkg::index_type'(mid_calc);
            if (lo_ff < hi1_ff) begin
               mid_in   = mid_calc;
               state_in = ST_LK_CMP;
            end else begin
               res_in   = '{srtl_pkg::STATUS_NOT_FOUND, '0, '0, '0};
               pend_in  = 1'b1;
               state_in = ST_IDLE;
            end
         end
         ST_LK_CMP: begin
            priority if (rd_entry.start_addr <= req_ff.probe_address &&
                         req_ff.probe_address <= rd_entry.end_addr) begin
               res_in   = '{srtl_pkg::STATUS_OK, rd_entry.start_addr, rd_entry.end_addr,
                            rd_entry.seq};
               pend_in  = 1'b1;
               state_in = ST_IDLE;
            end else if (rd_entry.start_addr > req_ff.probe_address) begin
               hi1_in   = mid_ff;
               state_in = ST_LK_RD;
            end else if (rd_entry.start_addr < req_ff.probe_address) begin
               lo_in    = mid_ff + srtl_pkg::count_type'(1);
               state_in = ST_LK_RD;
            end else begin
               // Start matches the probe but the range ends before it.
               res_in   = '{srtl_pkg::STATUS_NOT_FOUND, '0, '0, '0};
               pend_in  = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pend_ff      <= 1'b0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pend_ff      <= pend_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      req_ff      <= req_in;
      res_ff      <= res_in;
      idx_ff      <= idx_in;
      lo_ff       <= lo_in;
      hi1_ff      <= hi1_in;
      mid_ff      <= mid_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= srtl_pkg::CAP_COUNT)
      else $error("entry count exceeds table capacity");

   a_shift_index: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_INS_CMP) |-> (idx_ff != '0 && idx_ff <= count_ff))
      else $error("insert shift index out of range");

   a_probe_index: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_LK_CMP) |-> (mid_ff < count_ff && lo_ff <= mid_ff && mid_ff < hi1_ff))
      else $error("lookup probe outside the search window");

   a_count_step: assert property (@(posedge clock) disable iff (reset)
      (count_ff != $past(count_ff)) |-> (count_ff == $past(count_ff) + srtl_pkg::count_type'(1)
                                         && $rose(pend_ff)))
      else $error("entry count changed without a completed insert");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (pend_ff && rsp_valid_ff && rsp_stall) |=> $stable(res_ff) && pend_ff)
      else $error("pending result lost while output stalled");

endmodule

@@ test/srtl_range_checker.sv @@
// Checker for the sorted range table: predicts each result and compares it with the block.
module srtl_range_checker import srtl_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   input  logic    req_stall,
   input  req_type req_data,
   input  logic    rsp_valid,
   input  logic    rsp_stall,
   input  rsp_type rsp_data,
   output int      mismatches,
   output int      pending
);
   timeunit 1ns;
   timeprecision 1ps;

   addr_type range_lo  [CAPACITY];
   addr_type range_hi  [CAPACITY];
   seq_type  range_seq [CAPACITY];
   int       stored = 0;
   rsp_type  expected_q[$];
   int       error_total = 0;
   int       open_count = 0;

   assign mismatches = error_total;
   assign pending    = open_count;

   task automatic report_mismatch(string msg);
      $display("[%0t] mismatch: %s", $realtime, msg);
      error_total++;
   endtask

   // A new range goes after every stored range whose start is not above its own.
   function automatic rsp_type store_range(addr_type s, addr_type e);
      rsp_type r;
      int      pos;
      r = '0;
      if (stored >= CAPACITY) begin
         r.status = STATUS_FULL;
         return r;
      end
      pos = stored;
      while (pos > 0 && range_lo[pos-1] > s) pos--;
      for (int i = stored; i > pos; i--) begin
         range_lo[i]  = range_lo[i-1];
         range_hi[i]  = range_hi[i-1];
         range_seq[i] = range_seq[i-1];
      end
      range_lo[pos]  = s;
      range_hi[pos]  = e;
      range_seq[pos] = seq_type'(stored);
      stored++;
      r.status       = STATUS_OK;
      r.hit_start    = s;
      r.hit_end      = e;
      r.hit_sequence = range_seq[pos];
      return r;
   endfunction

   // The search gives up when it meets a start equal to the address that does not hold it.
   function automatic rsp_type search_range(addr_type a);
      rsp_type r;
      int      lo;
      int      hi;
      int      mid;
      r = '0;
      r.status = STATUS_NOT_FOUND;
      lo = 0;
      hi = stored - 1;
      while (lo <= hi) begin
         mid = lo + (hi - lo) / 2;
         if (range_lo[mid] <= a && a <= range_hi[mid]) begin
            r.status       = STATUS_OK;
            r.hit_start    = range_lo[mid];
            r.hit_end      = range_hi[mid];
            r.hit_sequence = range_seq[mid];
            return r;
         end
         if (range_lo[mid] > a) hi = mid - 1;
         else if (range_lo[mid] < a) lo = mid + 1;
         else break;
      end
      return r;
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         stored = 0;
         expected_q.delete();
         open_count <= 0;
      end else begin
         // Results are checked before requests so a same-edge request never matches early.
         if (rsp_valid && !rsp_stall) begin
            if (expected_q.size() == 0) begin
               report_mismatch($sformatf("result with nothing pending, status %0d",
                                         rsp_data.status));
            end else begin
               want = expected_q.pop_front();
               if (rsp_data.status !== want.status)
                  report_mismatch($sformatf("status got %0d expected %0d",
                                            rsp_data.status, want.status));
               if (rsp_data.hit_start !== want.hit_start)
                  report_mismatch($sformatf("hit_start got %h expected %h",
                                            rsp_data.hit_start, want.hit_start));
               if (rsp_data.hit_end !== want.hit_end)
                  report_mismatch($sformatf("hit_end got %h expected %h",
                                            rsp_data.hit_end, want.hit_end));
               if (rsp_data.hit_sequence !== want.hit_sequence)
                  report_mismatch($sformatf("hit_sequence got %0d expected %0d",
                                            rsp_data.hit_sequence, want.hit_sequence));
            end
         end
         if (req_valid && !req_stall) begin
            if (req_data.func == FUNC_INSERT)
               expected_q.push_back(store_range(req_data.range_start, req_data.range_end));
            else
               expected_q.push_back(search_range(req_data.probe_address));
         end
         open_count <= expected_q.size();
      end
   end

endmodule

@@ test/testbench.sv @@
// Top of the sorted range table testbench: clock, reset, stimulus, back-pressure and verdict.
module testbench import srtl_pkg::*; ();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int WATCHDOG_LIMIT = 20000;
   localparam int HOLD_CYCLES    = 1500;
   localparam int HOLD_AFTER     = 500;
   localparam int RANDOM_ITEMS   = 1330;

   logic     clock;
   logic     reset     = 1'b1;
   logic     req_valid = 1'b0;
   logic     req_stall;
   req_type  req_data  = '0;
   logic     rsp_valid;
   logic     rsp_stall = 1'b0;
   rsp_type  rsp_data;
   int       mismatches;
   int       pending;
   int       items_sent  = 0;
   int       idle_cycles = 0;
   addr_type known_start[$];
   addr_type known_end[$];

   sorted_range_table_lookup dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   srtl_range_checker u_checker (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_data   (req_data),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_data   (rsp_data),
      .mismatches (mismatches),
      .pending    (pending)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   function automatic addr_type any_addr();
      return {$urandom, $urandom};
   endfunction

   // Mostly no pause or a short one, now and then a long one.
   function automatic int rand_pause();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic int next_gap();
      if ((items_sent / 64) % 3 == 2) return 0;
      return rand_pause();
   endfunction

   task automatic offer(req_type item, int gap);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_data  <= item;
      req_valid <= 1'b1;
      do @(posedge clock); while (req_stall);
      items_sent++;
   endtask

   task automatic send_insert(addr_type s, addr_type e);
      req_type item;
      item.func          = FUNC_INSERT;
      item.range_start   = s;
      item.range_end     = e;
      item.probe_address = any_addr();
      if (known_start.size() < CAPACITY) begin
         known_start.push_back(s);
         known_end.push_back(e);
      end
      offer(item, next_gap());
   endtask

   task automatic send_lookup(addr_type p);
      req_type item;
      item.func          = FUNC_LOOKUP;
      item.range_start   = any_addr();
      item.range_end     = any_addr();
      item.probe_address = p;
      offer(item, next_gap());
   endtask

   task automatic send_random_insert();
      addr_type s;
      addr_type e;
      int       k;
      k = $urandom_range(0, 15);
      if (k == 0) begin
         s = any_addr();
         e = any_addr();
      end else if (k <= 2 && known_start.size() > 0) begin
         s = known_start[$urandom_range(0, known_start.size() - 1)];
         e = s + $urandom_range(0, 255);
      end else if (k == 3) begin
         s = any_addr();
         e = s - $urandom_range(1, 100);
      end else begin
         s = any_addr();
         e = s + $urandom_range(0, 4095);
      end
      send_insert(s, e);
   endtask

   // Most probes aim at a stored range, at its edges, inside it or just outside.
   function automatic addr_type pick_probe();
      int       k;
      addr_type s;
      addr_type e;
      addr_type span;
      if (known_start.size() == 0 || $urandom_range(0, 9) < 2) return any_addr();
      k = $urandom_range(0, known_start.size() - 1);
      s = known_start[k];
      e = known_end[k];
      case ($urandom_range(0, 5))
         0: return s;
         1: return e;
         2: return e + 1;
         3: return s - 1;
         default: begin
            span = e - s;
            if (e < s || span == '1) return any_addr();
            return s + any_addr() % (span + 1);
         end
      endcase
   endfunction

   initial begin
      bit do_insert;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Empty table, then the address extremes, equal starts and an inverted range.
      send_lookup('0);
      send_lookup('1);
      send_insert(64'h1000, 64'h1FFF);
      send_insert('0, '0);
      send_insert('1, '1);
      send_insert(64'h1000, 64'h10FF);
      send_insert(64'h5000, 64'h4000);
      send_insert(64'h8000, '1);
      send_lookup('0);
      send_lookup('1);
      send_lookup(64'h1800);
      send_lookup(64'h1000);
      send_lookup(64'h5000);
      send_lookup(64'h4800);
      send_lookup(64'h2000);
      send_lookup(64'h0FFF);
      send_insert(64'h5000, 64'h5000);
      send_lookup(64'h5000);
      send_lookup(64'h9000);

      // Inserts are about 45 percent of the items until the table is full; after that inserts only probe the full case.
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (known_start.size() < CAPACITY) do_insert = ($urandom_range(0, 99) < 45);
         else do_insert = ($urandom_range(0, 99) < 8);
         if (do_insert) send_random_insert();
         else send_lookup(pick_probe());
      end
      req_valid <= 1'b0;

      do @(posedge clock); while (pending != 0);
      repeat (20) @(posedge clock);
      if (mismatches == 0) $display("TEST PASSED");
      else $display("TEST FAILED");
      $finish;
   end

   // Result side back-pressure, with one long hold-off that backs the block up.
   initial begin
      int high_run;
      bit held;
      held = 1'b0;
      while (reset) @(posedge clock);
      forever begin
         if (!held && items_sent >= HOLD_AFTER) begin
            held = 1'b1;
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         if ($urandom_range(0, 9) == 0) repeat ($urandom_range(40, 200)) @(posedge clock);
         else repeat ($urandom_range(1, 10)) @(posedge clock);
         high_run = rand_pause();
         if (high_run > 0) begin
            rsp_stall <= 1'b1;
            repeat (high_run) @(posedge clock);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles == WATCHDOG_LIMIT) begin
            $display("TEST FAILED");
            $finish;
         end
      end
   end

endmodule

@@ sim.f @@
hw/rtl/srtl_pkg.sv
hw/rtl/srtl_ram.sv
hw/rtl/sorted_range_table_lookup.sv
test/srtl_range_checker.sv
test/testbench.sv
